// ----- rtl/core/ptpsf_pkg.sv -----
// Shared types and constants for the Sync / Follow_Up pairing block.
package ptpsf_pkg;

  // Configuration register indexes
  localparam int CfgIdxW = 3;
  localparam logic [CfgIdxW-1:0] REG_PORT_TRACKS_MASTER = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_PARENT_CLOCK_ID    = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_PARENT_PORT_NUMBER = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_PATH_ASYMMETRY     = 3'd3;

  // Nanoseconds in one second, for the origin timestamp conversion
  localparam logic [29:0] NS_PER_SEC = 30'd1000000000;

  // Message kinds
  localparam logic KIND_SYNC      = 1'b0;
  localparam logic KIND_FOLLOW_UP = 1'b1;

  // One parsed message descriptor
  typedef struct packed {
    logic               kind;
    logic [63:0]        source_clock_id;
    logic [15:0]        source_port;
    logic [15:0]        sequence_id;
    logic               one_step_flag;
    logic signed [63:0] correction_scaled;
    logic [62:0]        ingress_ns;
    logic [47:0]        origin_seconds;
    logic [29:0]        origin_nanoseconds;
    logic [62:0]        software_ns;
  } msg_t;

  // One paired result
  typedef struct packed {
    logic [62:0]        master_receive_ns;
    logic signed [63:0] corrected_origin_ns;
  } result_t;

  // One configuration write
  typedef struct packed {
    logic [CfgIdxW-1:0] index;
    logic [63:0]        data;
  } cfg_t;

  // Matched pair handed from the matcher to the time arithmetic
  typedef struct packed {
    logic [62:0]        t2;
    logic [47:0]        sec;
    logic [29:0]        nsec;
    logic signed [63:0] corr_a;
    logic signed [63:0] corr_b;
  } pair_t;

endpackage

// ----- rtl/core/ptpsf_if.sv -----
// Valid/ready channel interfaces for messages, results and configuration.
interface ptpsf_msg_if;
  logic            valid;
  logic            ready;
  ptpsf_pkg::msg_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface ptpsf_pair_if;
  logic               valid;
  logic               ready;
  ptpsf_pkg::result_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface ptpsf_cfg_if;
  logic            valid;
  logic            ready;
  ptpsf_pkg::cfg_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/core/ptpsf_match.sv -----
// Message filter, pairing state machine and configuration registers.
module ptpsf_match (
  input  logic             clk,
  input  logic             rst,
  ptpsf_msg_if.sink        msg,
  ptpsf_cfg_if.sink        cfg,
  output logic             pair_valid,
  output ptpsf_pkg::pair_t pair_data,
  input  logic             pair_ready
);

  localparam logic [1:0] PS_EMPTY = 2'd0;
  localparam logic [1:0] PS_SYNC  = 2'd1;
  localparam logic [1:0] PS_FUP   = 2'd2;

  // Configuration registers
  logic               port_tracks_master;
  logic [63:0]        parent_clock_id;
  logic [15:0]        parent_port_number;
  logic signed [63:0] path_asymmetry;

  // Input register
  logic            stage_valid;
  ptpsf_pkg::msg_t stage;

  // Pairing state
  logic [1:0]         pair_state;
  logic [1:0]         pair_state_next;
  logic [15:0]        held_sequence;
  logic signed [63:0] held_correction;
  logic [62:0]        held_stamp_ns;
  logic [47:0]        held_sec;
  logic [29:0]        held_nsec;
  logic [62:0]        held_software_ns;

  logic               src_ok;
  logic               emit;
  logic               hold_load;
  logic               done;
  logic signed [63:0] corr_sync;

  assign cfg.ready = 1'b1;

  // Configuration writes; unknown indexes are ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      port_tracks_master <= 1'b0;
      parent_clock_id    <= '0;
      parent_port_number <= '0;
      path_asymmetry     <= '0;
    end else if (cfg.valid) begin
      unique case (cfg.data.index)
        ptpsf_pkg::REG_PORT_TRACKS_MASTER: port_tracks_master <= cfg.data.data[0];
        ptpsf_pkg::REG_PARENT_CLOCK_ID:    parent_clock_id    <= cfg.data.data;
        ptpsf_pkg::REG_PARENT_PORT_NUMBER: parent_port_number <= cfg.data.data[15:0];
        ptpsf_pkg::REG_PATH_ASYMMETRY:     path_asymmetry     <= $signed(cfg.data.data);
        default: ;
      endcase
    end
  end

  // Input register takes a transfer when it is empty or the held item is finished
  assign done      = stage_valid && (!emit || pair_ready);
  assign msg.ready = !stage_valid || done;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (msg.ready) begin
      stage_valid <= msg.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (msg.valid && msg.ready) begin
      stage <= msg.data;
    end
  end

  // Filter and pairing decision
  assign src_ok = port_tracks_master &&
                  stage.source_clock_id == parent_clock_id &&
                  stage.source_port == parent_port_number;
  assign corr_sync = stage.correction_scaled + path_asymmetry;

  always_comb begin
    emit            = 1'b0;
    hold_load       = 1'b0;
    pair_state_next = pair_state;
    pair_data.t2     = stage.ingress_ns;
    pair_data.sec    = stage.origin_seconds;
    pair_data.nsec   = stage.origin_nanoseconds;
    pair_data.corr_a = corr_sync;
    pair_data.corr_b = '0;
    if (src_ok) begin
      if (stage.kind == ptpsf_pkg::KIND_SYNC) begin
        if (stage.one_step_flag) begin
          // one-step Sync carries its own origin time
          emit            = 1'b1;
          pair_state_next = PS_EMPTY;
        end else if (pair_state == PS_FUP && held_software_ns >= stage.software_ns &&
                     held_sequence == stage.sequence_id) begin
          emit             = 1'b1;
          pair_state_next  = PS_EMPTY;
          pair_data.sec    = held_sec;
          pair_data.nsec   = held_nsec;
          pair_data.corr_b = held_correction;
        end else begin
          hold_load       = 1'b1;
          pair_state_next = PS_SYNC;
        end
      end else begin
        pair_data.corr_a = held_correction;
        pair_data.corr_b = stage.correction_scaled;
        pair_data.t2     = held_stamp_ns;
        if (pair_state == PS_SYNC && held_sequence == stage.sequence_id) begin
          emit            = 1'b1;
          pair_state_next = PS_EMPTY;
        end else begin
          hold_load       = 1'b1;
          pair_state_next = PS_FUP;
        end
      end
    end
  end

  assign pair_valid = stage_valid && emit;

  // State update once the item leaves the input register
  always_ff @(posedge clk) begin
    if (rst) begin
      pair_state <= PS_EMPTY;
    end else if (done) begin
      pair_state <= pair_state_next;
    end
  end

  // A message from the parent that gives no result replaces what is held
  always_ff @(posedge clk) begin
    if (done && hold_load) begin
      held_sequence    <= stage.sequence_id;
      held_software_ns <= stage.software_ns;
      held_stamp_ns    <= stage.ingress_ns;
      held_sec         <= stage.origin_seconds;
      held_nsec        <= stage.origin_nanoseconds;
      held_correction  <= (stage.kind == ptpsf_pkg::KIND_SYNC) ? corr_sync
                                                               : stage.correction_scaled;
    end
  end

endmodule

// ----- rtl/core/ptpsf_arith.sv -----
// Time arithmetic pipeline: origin conversion and correction sum.
module ptpsf_arith (
  input  logic             clk,
  input  logic             rst,
  input  logic             pair_valid,
  input  ptpsf_pkg::pair_t pair_data,
  output logic             pair_ready,
  ptpsf_pair_if.source     pair
);

  // Stage A: matched pair
  logic             a_valid;
  ptpsf_pkg::pair_t a;
  // Stage B: partial products and correction sum
  logic        b_valid;
  logic [61:0] b_plo;
  logic [45:0] b_phi;
  logic [29:0] b_nsec;
  logic [63:0] b_csum;
  logic [62:0] b_t2;
  // Stage C: origin in nanoseconds
  logic        c_valid;
  logic [63:0] c_origin;
  logic [63:0] c_csum;
  logic [62:0] c_t2;

  logic adv_out, adv_c, adv_b, adv_a;

  // Each stage moves when the one after it has room
  assign adv_out    = !pair.valid || pair.ready;
  assign adv_c      = !c_valid || adv_out;
  assign adv_b      = !b_valid || adv_c;
  assign adv_a      = !a_valid || adv_b;
  assign pair_ready = adv_a;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid    <= 1'b0;
      b_valid    <= 1'b0;
      c_valid    <= 1'b0;
      pair.valid <= 1'b0;
    end else begin
      if (adv_a)   a_valid    <= pair_valid;
      if (adv_b)   b_valid    <= a_valid;
      if (adv_c)   c_valid    <= b_valid;
      if (adv_out) pair.valid <= c_valid;
    end
  end

  // Stage A load
  always_ff @(posedge clk) begin
    if (adv_a && pair_valid) begin
      a <= pair_data;
    end
  end

  // Seconds split into low 32 and high 16 bits for the multiply
  always_ff @(posedge clk) begin
    if (adv_b && a_valid) begin
      b_plo  <= 62'(a.sec[31:0]) * 62'(ptpsf_pkg::NS_PER_SEC);
      b_phi  <= 46'(a.sec[47:32]) * 46'(ptpsf_pkg::NS_PER_SEC);
      b_nsec <= a.nsec;
      b_csum <= 64'($signed(a.corr_a) >>> 16) + 64'($signed(a.corr_b) >>> 16);
      b_t2   <= a.t2;
    end
  end

  // Origin time wraps modulo 2^64
  always_ff @(posedge clk) begin
    if (adv_c && b_valid) begin
      c_origin <= {2'b00, b_plo} + {b_phi[31:0], 32'd0} + {34'd0, b_nsec};
      c_csum   <= b_csum;
      c_t2     <= b_t2;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (adv_out && c_valid) begin
      pair.data.master_receive_ns   <= c_t2;
      pair.data.corrected_origin_ns <= $signed(c_origin + c_csum);
    end
  end

endmodule

// ----- rtl/core/ptp_sync_followup_pairing_top.sv -----
// Top level of the Sync / Follow_Up pairing block.
//
// Channels: msg takes one parsed Sync or Follow_Up descriptor per transfer,
// pair gives one result (t2 and corrected origin time) per matched pair or
// one-step Sync, cfg writes the four configuration registers by index.
// Messages from a source other than the configured parent, or while the
// port does not track a master, are consumed without a result.
// Throughput: one message per cycle unless a stalled receiver holds msg
// off (see below); cfg.ready is always high.
// Path: a message passes the input register, then arithmetic stage A
// (the matched pair), stage B (split seconds multiply and correction sum),
// stage C (origin sum) and the result register; matching is combinational.
// The 48 x 30 bit seconds conversion is done as two partial products in
// their own stage.
// Reset (rst, synchronous) clears the pipeline, empties the pairing state
// and sets all configuration registers to zero.
// When the receiver stalls, results queue in the four arithmetic registers;
// msg stays ready until they are full and the input register holds a
// message that gives a result.
module ptp_sync_followup_pairing_top (
  input  logic         clk,
  input  logic         rst,
  ptpsf_msg_if.sink    msg,
  ptpsf_pair_if.source pair,
  ptpsf_cfg_if.sink    cfg
);

  logic             match_valid;
  logic             match_ready;
  ptpsf_pkg::pair_t match_data;

  ptpsf_match u_match (
    .clk        (clk),
    .rst        (rst),
    .msg        (msg),
    .cfg        (cfg),
    .pair_valid (match_valid),
    .pair_data  (match_data),
    .pair_ready (match_ready)
  );

  ptpsf_arith u_arith (
    .clk        (clk),
    .rst        (rst),
    .pair_valid (match_valid),
    .pair_data  (match_data),
    .pair_ready (match_ready),
    .pair       (pair)
  );

endmodule

// ----- rtl/core/ptpsf_checker.sv -----
// Port-level checks for the pairing block and their bind.
module ptpsf_checker (
  input logic               clk,
  input logic               rst,
  input logic               msg_ready,
  input logic               pair_valid,
  input logic               pair_ready,
  input ptpsf_pkg::result_t pair_data
);

  // A stalled result holds
  assert property (@(posedge clk) disable iff (rst)
    pair_valid && !pair_ready |=> pair_valid && $stable(pair_data))
    else $error("stalled result changed");

  // No result can come out before the pipeline has refilled after reset
  assert property (@(posedge clk) disable iff (rst)
    $past(rst, 1) || $past(rst, 2) || $past(rst, 3) || $past(rst, 4) |-> !pair_valid)
    else $error("result too soon after reset");

  // With the result side free, the message side is never held off
  assert property (@(posedge clk) disable iff (rst)
    !pair_valid || pair_ready |-> msg_ready)
    else $error("message side stalled with free result side");

endmodule

bind ptp_sync_followup_pairing_top ptpsf_checker u_checker (
  .clk        (clk),
  .rst        (rst),
  .msg_ready  (msg.ready),
  .pair_valid (pair.valid),
  .pair_ready (pair.ready),
  .pair_data  (pair.data)
);

// ----- test/ptpsf_pair_checker.sv -----
// Checker for the Sync / Follow_Up pairing block: predicts pair results and compares them.
`timescale 1ns / 100ps

module ptpsf_pair_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               msg_valid,
  input  logic               msg_ready,
  input  ptpsf_pkg::msg_t    msg_data,
  input  logic               pair_valid,
  input  logic               pair_ready,
  input  ptpsf_pkg::result_t pair_data,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  ptpsf_pkg::cfg_t    cfg_data,
  output int                 errors,
  output int                 pending
);

  typedef enum logic [1:0] {
    HOLD_NONE,
    HOLD_SYNC,
    HOLD_FOLLOW_UP
  } hold_t;

  // Configuration copy
  logic        tracks_master;
  logic [63:0] parent_id;
  logic [15:0] parent_port;
  logic [63:0] asymmetry;

  // Pairing state copy
  hold_t       hold_state;
  logic [15:0] hold_seq;
  logic [63:0] hold_corr;
  logic [63:0] hold_stamp;
  logic [62:0] hold_sw;

  ptpsf_pkg::result_t expected_pairs[$];

  // Scaled nanoseconds to nanoseconds, rounding toward minus infinity
  function automatic logic [63:0] scaled_ns(input logic [63:0] c);
    logic signed [63:0] cs;
    cs = c;
    return cs >>> 16;
  endfunction

  function automatic logic [63:0] origin_ns(input logic [47:0] sec, input logic [29:0] nsec);
    return 64'(sec) * 64'(ptpsf_pkg::NS_PER_SEC) + 64'(nsec);
  endfunction

  task automatic push_pair(input logic [63:0] t2, input logic [63:0] t1,
                           input logic [63:0] c1, input logic [63:0] c2);
    ptpsf_pkg::result_t r;
    r.master_receive_ns   = t2[62:0];
    r.corrected_origin_ns = t1 + (scaled_ns(c1) + scaled_ns(c2));
    expected_pairs.push_back(r);
  endtask

  // Next pairing state and result for one accepted message
  task automatic predict_pair(input ptpsf_pkg::msg_t m);
    logic [63:0] corr;
    logic [63:0] origin;
    corr   = m.correction_scaled;
    origin = origin_ns(m.origin_seconds, m.origin_nanoseconds);
    if (!tracks_master || m.source_clock_id != parent_id || m.source_port != parent_port) begin
      return;
    end
    if (m.kind == ptpsf_pkg::KIND_SYNC) begin
      corr = corr + asymmetry;
      if (m.one_step_flag) begin
        hold_state = HOLD_NONE;
        push_pair(64'(m.ingress_ns), origin, corr, 64'd0);
      end else if (hold_state == HOLD_FOLLOW_UP && hold_sw >= m.software_ns &&
                   hold_seq == m.sequence_id) begin
        hold_state = HOLD_NONE;
        push_pair(64'(m.ingress_ns), hold_stamp, corr, hold_corr);
      end else begin
        hold_state = HOLD_SYNC;
        hold_seq   = m.sequence_id;
        hold_corr  = corr;
        hold_stamp = 64'(m.ingress_ns);
        hold_sw    = m.software_ns;
      end
    end else if (hold_state == HOLD_SYNC && hold_seq == m.sequence_id) begin
      hold_state = HOLD_NONE;
      push_pair(hold_stamp, origin, hold_corr, corr);
    end else begin
      hold_state = HOLD_FOLLOW_UP;
      hold_seq   = m.sequence_id;
      hold_corr  = corr;
      hold_stamp = origin;
      hold_sw    = m.software_ns;
    end
  endtask

  always @(posedge clk) begin
    ptpsf_pkg::result_t exp_pair;
    if (rst) begin
      tracks_master = 1'b0;
      parent_id     = '0;
      parent_port   = '0;
      asymmetry     = '0;
      hold_state    = HOLD_NONE;
      hold_seq      = '0;
      hold_corr     = '0;
      hold_stamp    = '0;
      hold_sw       = '0;
      expected_pairs.delete();
      errors        = 0;
    end else begin
      // result transfer: compare with the oldest expectation
      if (pair_valid && pair_ready) begin
        if (expected_pairs.size() == 0) begin
          $display("%0t: result with none expected: t2 %h origin %h", $time,
                   pair_data.master_receive_ns, pair_data.corrected_origin_ns);
          errors++;
        end else begin
          exp_pair = expected_pairs.pop_front();
          if (pair_data.master_receive_ns !== exp_pair.master_receive_ns) begin
            $display("%0t: master_receive_ns expected %h actual %h", $time,
                     exp_pair.master_receive_ns, pair_data.master_receive_ns);
            errors++;
          end
          if (pair_data.corrected_origin_ns !== exp_pair.corrected_origin_ns) begin
            $display("%0t: corrected_origin_ns expected %h actual %h", $time,
                     exp_pair.corrected_origin_ns, pair_data.corrected_origin_ns);
            errors++;
          end
        end
      end
      // register write
      if (cfg_valid && cfg_ready) begin
        case (cfg_data.index)
          ptpsf_pkg::REG_PORT_TRACKS_MASTER: tracks_master = cfg_data.data[0];
          ptpsf_pkg::REG_PARENT_CLOCK_ID:    parent_id     = cfg_data.data;
          ptpsf_pkg::REG_PARENT_PORT_NUMBER: parent_port   = cfg_data.data[15:0];
          ptpsf_pkg::REG_PATH_ASYMMETRY:     asymmetry     = cfg_data.data;
          default: ;
        endcase
      end
      // message transfer
      if (msg_valid && msg_ready) begin
        predict_pair(msg_data);
      end
    end
    pending = expected_pairs.size();
  end

endmodule

// ----- test/tb_ptp_sync_followup_pairing_top.sv -----
// Testbench top for the Sync / Follow_Up pairing block: stimulus, idling and verdict.
`timescale 1ns / 100ps

module tb_ptp_sync_followup_pairing_top;

  localparam int CYCLE_LIMIT = 200000;
  localparam logic [ptpsf_pkg::CfgIdxW-1:0] REG_SPARE = 3'd7;
  localparam logic [63:0] ASYM_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] ASYM_MIN = 64'h8000_0000_0000_0000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   errors;
  int   pending;
  int   cycle_count = 0;
  int   items_sent = 0;
  int   send_idle_pct = 0;
  int   stall_pct = 0;

  // Identity that matching messages carry
  logic [63:0] par_clock_id = '0;
  logic [15:0] par_port = '0;

  ptpsf_msg_if  msg_ch ();
  ptpsf_pair_if pair_ch ();
  ptpsf_cfg_if  cfg_ch ();

  ptp_sync_followup_pairing_top DUT (
    .clk  (clk),
    .rst  (rst),
    .msg  (msg_ch),
    .pair (pair_ch),
    .cfg  (cfg_ch)
  );

  ptpsf_pair_checker pair_check (
    .clk        (clk),
    .rst        (rst),
    .msg_valid  (msg_ch.valid),
    .msg_ready  (msg_ch.ready),
    .msg_data   (msg_ch.data),
    .pair_valid (pair_ch.valid),
    .pair_ready (pair_ch.ready),
    .pair_data  (pair_ch.data),
    .cfg_valid  (cfg_ch.valid),
    .cfg_ready  (cfg_ch.ready),
    .cfg_data   (cfg_ch.data),
    .errors     (errors),
    .pending    (pending)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Receiver stalls
  always @(negedge clk) begin
    pair_ch.ready <= ($urandom_range(99) >= stall_pct);
  end

  // Run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Small signed value, both signs
  function automatic logic [63:0] small_signed64();
    logic sgn;
    sgn = 1'($urandom_range(1));
    return {{40{sgn}}, 24'($urandom)};
  endfunction

  function automatic ptpsf_pkg::msg_t rand_msg(input logic kind, input logic [15:0] seq,
                                               input logic single_step);
    ptpsf_pkg::msg_t m;
    m.kind            = kind;
    m.source_clock_id = par_clock_id;
    m.source_port     = par_port;
    m.sequence_id     = seq;
    m.one_step_flag   = single_step;
    case ($urandom_range(9))
      0:       m.correction_scaled = ASYM_MAX;
      1:       m.correction_scaled = ASYM_MIN;
      2, 3, 4: m.correction_scaled = small_signed64();
      default: m.correction_scaled = rand64();
    endcase
    m.ingress_ns = 63'(rand64());
    case ($urandom_range(9))
      0:       m.origin_seconds = '1;
      1:       m.origin_seconds = '0;
      default: m.origin_seconds = 48'(rand64());
    endcase
    m.origin_nanoseconds = ($urandom_range(7) == 0) ? 30'($urandom)
                                                    : 30'($urandom_range(999999999));
    m.software_ns = ($urandom_range(3) == 0) ? '0 : 63'(rand64());
    return m;
  endfunction

  task automatic send_msg(input ptpsf_pkg::msg_t m);
    while ($urandom_range(99) < send_idle_pct) begin
      msg_ch.valid <= 1'b0;
      @(negedge clk);
    end
    msg_ch.valid <= 1'b1;
    msg_ch.data  <= m;
    do @(posedge clk); while (!msg_ch.ready);
    @(negedge clk);
    items_sent++;
  endtask

  task automatic write_reg(input logic [ptpsf_pkg::CfgIdxW-1:0] idx,
                           input logic [63:0] value);
    cfg_ch.valid      <= 1'b1;
    cfg_ch.data.index <= idx;
    cfg_ch.data.data  <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
  endtask

  // All registers, unused bits random; the spare index must change nothing
  task automatic configure(input logic tracks, input logic [63:0] id,
                           input logic [15:0] port, input logic [63:0] asym);
    write_reg(ptpsf_pkg::REG_PORT_TRACKS_MASTER, {63'(rand64()), tracks});
    write_reg(ptpsf_pkg::REG_PARENT_CLOCK_ID, id);
    write_reg(ptpsf_pkg::REG_PARENT_PORT_NUMBER, {48'(rand64()), port});
    write_reg(ptpsf_pkg::REG_PATH_ASYMMETRY, asym);
    write_reg(REG_SPARE, rand64());
    cfg_ch.valid <= 1'b0;
    par_clock_id = id;
    par_port     = port;
  endtask

  // Wait until every result is in and the pipeline has emptied
  task automatic drain();
    msg_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (10) @(negedge clk);
  endtask

  // One exchange: mostly well formed pairs, some noise and broken pairs
  task automatic run_exchange();
    ptpsf_pkg::msg_t s;
    ptpsf_pkg::msg_t f;
    ptpsf_pkg::msg_t n;
    int   r;
    logic [15:0] seq;
    r   = $urandom_range(99);
    seq = 16'($urandom);
    s   = rand_msg(ptpsf_pkg::KIND_SYNC, seq, 1'b0);
    f   = rand_msg(ptpsf_pkg::KIND_FOLLOW_UP, seq, 1'($urandom_range(1)));
    if (r < 15) begin
      s.one_step_flag = 1'b1;
      send_msg(s);
    end else if (r < 50) begin
      send_msg(s);
      send_msg(f);
    end else if (r < 75) begin
      // Follow_Up first; the Sync software stamp decides the order check
      case ($urandom_range(3))
        0:       s.software_ns = f.software_ns;
        1:       s.software_ns = f.software_ns + 63'd1 + 63'($urandom_range(1000));
        default: s.software_ns = f.software_ns >> $urandom_range(1, 8);
      endcase
      send_msg(f);
      send_msg(s);
    end else if (r < 90) begin
      n = rand_msg(1'($urandom_range(1)), seq, 1'($urandom_range(1)));
      case ($urandom_range(2))
        0: n.source_clock_id = n.source_clock_id ^ (64'd1 << $urandom_range(63));
        1: n.source_port = n.source_port ^ (16'd1 << $urandom_range(15));
        default: begin
          n.source_clock_id = rand64();
          n.source_port     = 16'($urandom);
        end
      endcase
      send_msg(n);
    end else begin
      f.sequence_id = ($urandom_range(1) == 0) ? seq + 16'd1 : 16'($urandom);
      send_msg(s);
      send_msg(f);
    end
  endtask

  initial begin
    ptpsf_pkg::msg_t m;
    int   first_item;
    int   target;
    msg_ch.valid  = 1'b0;
    msg_ch.data   = '0;
    cfg_ch.valid  = 1'b0;
    cfg_ch.data   = '0;
    repeat (7) @(negedge clk);
    rst <= 1'b0;

    // After reset the port does not track a master: a matching Sync is dropped
    send_msg(rand_msg(ptpsf_pkg::KIND_SYNC, 16'h0000, 1'b1));
    drain();
    configure(1'b1, 64'hA5C3_0F1E_9B24_7D68, 16'h5A5A, 64'h0000_0000_0003_8000);

    // One-step Sync at the top and bottom of every field
    m = rand_msg(ptpsf_pkg::KIND_SYNC, 16'hFFFF, 1'b1);
    m.correction_scaled  = ASYM_MAX;
    m.ingress_ns         = '1;
    m.origin_seconds     = '1;
    m.origin_nanoseconds = '1;
    m.software_ns        = '1;
    send_msg(m);
    m = rand_msg(ptpsf_pkg::KIND_SYNC, 16'h0000, 1'b1);
    m.correction_scaled  = ASYM_MIN;
    m.ingress_ns         = '0;
    m.origin_seconds     = '0;
    m.origin_nanoseconds = '0;
    m.software_ns        = '0;
    send_msg(m);

    // Sync then Follow_Up
    send_msg(rand_msg(ptpsf_pkg::KIND_SYNC, 16'd5, 1'b0));
    send_msg(rand_msg(ptpsf_pkg::KIND_FOLLOW_UP, 16'd5, 1'b0));

    // Follow_Up then Sync with equal software stamps
    m = rand_msg(ptpsf_pkg::KIND_FOLLOW_UP, 16'd7, 1'b0);
    m.software_ns = 63'd100;
    send_msg(m);
    m = rand_msg(ptpsf_pkg::KIND_SYNC, 16'd7, 1'b0);
    m.software_ns = 63'd100;
    send_msg(m);

    // Order check fails: the Sync is held and pairs with the next Follow_Up
    m = rand_msg(ptpsf_pkg::KIND_FOLLOW_UP, 16'd8, 1'b0);
    m.software_ns = 63'd100;
    send_msg(m);
    m = rand_msg(ptpsf_pkg::KIND_SYNC, 16'd8, 1'b0);
    m.software_ns = 63'd101;
    send_msg(m);
    send_msg(rand_msg(ptpsf_pkg::KIND_FOLLOW_UP, 16'd8, 1'b0));

    // Mismatched sequence ids replace what is held
    send_msg(rand_msg(ptpsf_pkg::KIND_SYNC, 16'd1, 1'b0));
    send_msg(rand_msg(ptpsf_pkg::KIND_SYNC, 16'd2, 1'b0));
    send_msg(rand_msg(ptpsf_pkg::KIND_FOLLOW_UP, 16'd1, 1'b0));
    m = rand_msg(ptpsf_pkg::KIND_SYNC, 16'd1, 1'b0);
    m.software_ns = '0;
    send_msg(m);

    // Foreign clock identity, then foreign port
    m = rand_msg(ptpsf_pkg::KIND_SYNC, 16'd3, 1'b1);
    m.source_clock_id = ~m.source_clock_id;
    send_msg(m);
    m = rand_msg(ptpsf_pkg::KIND_SYNC, 16'd3, 1'b1);
    m.source_port = m.source_port ^ 16'h0001;
    send_msg(m);

    // Flag ignored on Follow_Up; a one-step Sync empties the held Follow_Up
    send_msg(rand_msg(ptpsf_pkg::KIND_FOLLOW_UP, 16'd9, 1'b1));
    send_msg(rand_msg(ptpsf_pkg::KIND_SYNC, 16'd9, 1'b1));
    m = rand_msg(ptpsf_pkg::KIND_SYNC, 16'd9, 1'b0);
    m.software_ns = '0;
    send_msg(m);
    send_msg(rand_msg(ptpsf_pkg::KIND_FOLLOW_UP, 16'd9, 1'b0));

    // Highest sequence id
    send_msg(rand_msg(ptpsf_pkg::KIND_SYNC, 16'hFFFF, 1'b0));
    send_msg(rand_msg(ptpsf_pkg::KIND_FOLLOW_UP, 16'hFFFF, 1'b0));
    drain();

    // Random phases, each with a new setting and one of four idling modes
    for (int p = 0; p < 9; p++) begin
      case (p)
        0:       configure(1'b1, rand64(), 16'($urandom), 64'd0);
        1:       configure(1'b1, 64'd0, 16'h0000, ASYM_MAX);
        2:       configure(1'b1, '1, 16'hFFFF, ASYM_MIN);
        3:       configure(1'b1, rand64(), 16'($urandom), rand64());
        4:       configure(1'b0, par_clock_id, par_port, small_signed64());
        default: configure(1'b1, rand64(), 16'($urandom), small_signed64());
      endcase
      case (p % 4)
        0: begin
          send_idle_pct = 0;
          stall_pct     = 0;
        end
        1: begin
          send_idle_pct = 58;
          stall_pct     = 0;
        end
        2: begin
          send_idle_pct = 0;
          stall_pct     = 58;
        end
        default: begin
          send_idle_pct = 35;
          stall_pct     = 35;
        end
      endcase
      target     = (p == 4) ? 12 : 55;
      first_item = items_sent;
      while (items_sent - first_item < target) run_exchange();
      drain();
    end

    repeat (10) @(negedge clk);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/core/ptpsf_pkg.sv
rtl/core/ptpsf_if.sv
rtl/core/ptpsf_match.sv
rtl/core/ptpsf_arith.sv
rtl/core/ptp_sync_followup_pairing_top.sv
rtl/core/ptpsf_checker.sv
test/ptpsf_pair_checker.sv
test/tb_ptp_sync_followup_pairing_top.sv
